/* src/hcsk_pkg.sv */
// HChaCha20 subkey derivation: shared types, constants and the quarter-round step function.
// No dependencies; used by hcsk_cell and hchacha20_subkey_derive_unit.
`timescale 1ns / 1ps

package hcsk_pkg;

    localparam int WORD_W        = 32;
    localparam int NUM_WORDS     = 16;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int QR_STEPS      = 4;
    // one cell per quarter-round step of every half round
    localparam int NUM_CELLS     = DOUBLE_ROUNDS * 2 * QR_STEPS;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

    localparam logic [4:0] ROT_16 = 5'd16;
    localparam logic [4:0] ROT_12 = 5'd12;
    localparam logic [4:0] ROT_8  = 5'd8;
    localparam logic [4:0] ROT_7  = 5'd7;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

    // the four add/xor/rotate steps of a quarter round
    typedef enum logic [1:0] {
        QR_AD16 = 2'd0,
        QR_CB12 = 2'd1,
        QR_AD8  = 2'd2,
        QR_CB7  = 2'd3
    } qr_step_t;

    typedef struct packed {
        qr_step_t step;
        logic     diag;
    } cell_ctrl_t;

    typedef struct packed {
        logic [63:0] key_part_0;
        logic [63:0] key_part_1;
        logic [63:0] key_part_2;
        logic [63:0] key_part_3;
        logic [63:0] nonce_part_0;
        logic [63:0] nonce_part_1;
    } item_t;

    typedef struct packed {
        logic [63:0] subkey_part_0;
        logic [63:0] subkey_part_1;
        logic [63:0] subkey_part_2;
        logic [63:0] subkey_part_3;
    } result_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] amt);
        logic [5:0] rev;
        begin
            rev  = 6'd32 - {1'b0, amt};
            rotl = (v << amt) | (v >> rev);
        end
    endfunction

    // Apply one step to all four quarter rounds of a column or diagonal half round.
    function automatic state_t qr_step(input state_t s, input qr_step_t step,
                                       input logic diag);
        state_t           r;
        logic [1:0]       col;
        logic [1:0]       off_b;
        logic [1:0]       off_c;
        logic [1:0]       off_d;
        logic [3:0]       ia;
        logic [3:0]       ib;
        logic [3:0]       ic;
        logic [3:0]       id;
        logic [WORD_W-1:0] sum_ab;
        logic [WORD_W-1:0] sum_cd;
        begin
            r     = s;
            off_b = diag ? 2'd1 : 2'd0;
            off_c = diag ? 2'd2 : 2'd0;
            off_d = diag ? 2'd3 : 2'd0;
            for (int i = 0; i < 4; i++) begin
                col    = 2'(i);
                ia     = {2'd0, col};
                ib     = {2'd1, 2'(col + off_b)};
                ic     = {2'd2, 2'(col + off_c)};
                id     = {2'd3, 2'(col + off_d)};
                sum_ab = s[ia] + s[ib];
                sum_cd = s[ic] + s[id];
                case (step)
                    QR_AD16:
                    begin
                        r[ia] = sum_ab;
                        r[id] = rotl(s[id] ^ sum_ab, ROT_16);
                    end
                    QR_CB12:
                    begin
                        r[ic] = sum_cd;
                        r[ib] = rotl(s[ib] ^ sum_cd, ROT_12);
                    end
                    QR_AD8:
                    begin
                        r[ia] = sum_ab;
                        r[id] = rotl(s[id] ^ sum_ab, ROT_8);
                    end
                    QR_CB7:
                    begin
                        r[ic] = sum_cd;
                        r[ib] = rotl(s[ib] ^ sum_cd, ROT_7);
                    end
                    default:
                    begin
                        r[ia] = s[ia];
                    end
                endcase
            end
            qr_step = r;
        end
    endfunction

endpackage

/* src/hcsk_cell.sv */
// One pipeline cell: a single quarter-round step on the full 16-word state.
// Depends on hcsk_pkg.
`timescale 1ns / 1ps

module hcsk_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hcsk_pkg::cell_ctrl_t ctrl,
    input  logic                valid_in,
    input  hcsk_pkg::state_t    state_in,
    output logic                valid_out,
    output hcsk_pkg::state_t    state_out
);

    logic             valid_reg;
    hcsk_pkg::state_t state_reg;
    hcsk_pkg::state_t state_next;

    assign state_next = hcsk_pkg::qr_step(state_in, ctrl.step, ctrl.diag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // payload moves every cycle; valid qualifies it
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

/* src/hchacha20_subkey_derive_unit.sv */
// HChaCha20 subkey derivation: 80-cell pipeline, one quarter-round step per cell.
// Result strobed on done from the last of the 80 cell registers after the transaction is accepted.
// Throughput: one transaction per cycle; busy is never asserted, so start may be
// held high every cycle. Results are not held: done lasts exactly one cycle.
// Reset (rst_n, async, active low) drops all in-flight transactions; no output follows.
// Depends on hcsk_pkg and hcsk_cell.
`timescale 1ns / 1ps

module hchacha20_subkey_derive_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hcsk_pkg::item_t   item,
    output logic              done,
    output hcsk_pkg::result_t result
);

    localparam int NC = hcsk_pkg::NUM_CELLS;

    // chain taps: index 0 is the loaded state, index k the output of cell k-1
    logic [NC:0]                 valid_chain;
    hcsk_pkg::state_t [NC:0]     state_chain;
    hcsk_pkg::state_t            init_state;

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy = 1'b0;

    // Initial ChaCha state: sigma, key words (little endian), nonce words.
    always_comb
    begin
        init_state[0]  = hcsk_pkg::SIGMA_0;
        init_state[1]  = hcsk_pkg::SIGMA_1;
        init_state[2]  = hcsk_pkg::SIGMA_2;
        init_state[3]  = hcsk_pkg::SIGMA_3;
        init_state[4]  = item.key_part_0[31:0];
        init_state[5]  = item.key_part_0[63:32];
        init_state[6]  = item.key_part_1[31:0];
        init_state[7]  = item.key_part_1[63:32];
        init_state[8]  = item.key_part_2[31:0];
        init_state[9]  = item.key_part_2[63:32];
        init_state[10] = item.key_part_3[31:0];
        init_state[11] = item.key_part_3[63:32];
        init_state[12] = item.nonce_part_0[31:0];
        init_state[13] = item.nonce_part_0[63:32];
        init_state[14] = item.nonce_part_1[31:0];
        init_state[15] = item.nonce_part_1[63:32];
    end

    assign valid_chain[0] = start & ~busy;
    assign state_chain[0] = init_state;

    // Cell g runs step (g mod 4) of a column half round when (g/4) is even,
    // of a diagonal half round when odd. Twenty half rounds, no feed-forward.
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        localparam int StepIdx = g % hcsk_pkg::QR_STEPS;
        localparam int DiagIdx = (g / hcsk_pkg::QR_STEPS) % 2;

        hcsk_pkg::cell_ctrl_t ctrl;

        assign ctrl.step = hcsk_pkg::qr_step_t'(2'(StepIdx));
        assign ctrl.diag = 1'(DiagIdx);

        hcsk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .valid_in  (valid_chain[g]),
            .state_in  (state_chain[g]),
            .valid_out (valid_chain[g+1]),
            .state_out (state_chain[g+1])
        );
    end

    // Subkey: words 0..3 and 12..15, straight from the last cell's register.
    assign done                 = valid_chain[NC];
    assign result.subkey_part_0 = {state_chain[NC][1],  state_chain[NC][0]};
    assign result.subkey_part_1 = {state_chain[NC][3],  state_chain[NC][2]};
    assign result.subkey_part_2 = {state_chain[NC][13], state_chain[NC][12]};
    assign result.subkey_part_3 = {state_chain[NC][15], state_chain[NC][14]};

    // every result traces back to a transaction accepted at the head of the chain
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NC))
        else $error("done without a matching accepted transaction");

    // reset empties the chain
    a_no_done_in_reset: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("done strobed while in reset");

    // mid-chain check: the halfway tap tracks the input
    a_mid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_chain[NC/2] |-> $past(valid_chain[0], NC/2))
        else $error("halfway tap valid without a transaction behind it");

endmodule

/* dv/tb_top.sv */
// Testbench for hchacha20_subkey_derive_unit: directed and random key/nonce transactions,
// each checked against a behavioral HChaCha20 model held in a small scoreboard class.
// Depends on hcsk_pkg (item_t, result_t) and the RTL of hchacha20_subkey_derive_unit.
`timescale 1ns / 1ps

module tb_top;

    // HChaCha20 state constants ("expand 32-byte k") and round count
    localparam logic [31:0] EXPAND_0     = 32'h61707865;
    localparam logic [31:0] EXPAND_1     = 32'h3320646e;
    localparam logic [31:0] EXPAND_2     = 32'h79622d32;
    localparam logic [31:0] EXPAND_3     = 32'h6b206574;
    localparam int          DBL_ROUNDS   = 10;

    localparam int          RANDOM_ITEMS = 1850;
    // pipeline depth is 80 cells; drain wait allows some margin on top
    localparam int          DRAIN_CYCLES = 120;
    // limit is several times the slowest legal run
    localparam int          CYCLE_LIMIT  = 1_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the subkey of every accepted transaction and
    // checks results in order (pipeline never reorders).
    // ------------------------------------------------------------------
    class subkey_scoreboard;
        hcsk_pkg::result_t subkeys_due[$];
        int unsigned       mismatches;
        logic [31:0]       ws[16];

        function new();
            mismatches = 0;
        endfunction

        function logic [31:0] rol32(logic [31:0] x, int unsigned n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // one full quarter round on state words a, b, c, d
        function void quarter(int a, int b, int c, int d);
            ws[a] = ws[a] + ws[b];  ws[d] = rol32(ws[d] ^ ws[a], 16);
            ws[c] = ws[c] + ws[d];  ws[b] = rol32(ws[b] ^ ws[c], 12);
            ws[a] = ws[a] + ws[b];  ws[d] = rol32(ws[d] ^ ws[a], 8);
            ws[c] = ws[c] + ws[d];  ws[b] = rol32(ws[b] ^ ws[c], 7);
        endfunction

        function hcsk_pkg::result_t hchacha_subkey(hcsk_pkg::item_t it);
            hcsk_pkg::result_t sk;
            ws[0]  = EXPAND_0;
            ws[1]  = EXPAND_1;
            ws[2]  = EXPAND_2;
            ws[3]  = EXPAND_3;
            // low half of each 64-bit field is the first little-endian word
            ws[4]  = it.key_part_0[31:0];    ws[5]  = it.key_part_0[63:32];
            ws[6]  = it.key_part_1[31:0];    ws[7]  = it.key_part_1[63:32];
            ws[8]  = it.key_part_2[31:0];    ws[9]  = it.key_part_2[63:32];
            ws[10] = it.key_part_3[31:0];    ws[11] = it.key_part_3[63:32];
            ws[12] = it.nonce_part_0[31:0];  ws[13] = it.nonce_part_0[63:32];
            ws[14] = it.nonce_part_1[31:0];  ws[15] = it.nonce_part_1[63:32];
            for (int r = 0; r < DBL_ROUNDS; r++)
            begin
                // columns
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                // diagonals
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            // no feed-forward: subkey is raw words 0..3 and 12..15
            sk.subkey_part_0 = {ws[1], ws[0]};
            sk.subkey_part_1 = {ws[3], ws[2]};
            sk.subkey_part_2 = {ws[13], ws[12]};
            sk.subkey_part_3 = {ws[15], ws[14]};
            return sk;
        endfunction

        function void note_item(hcsk_pkg::item_t it);
            subkeys_due.push_back(hchacha_subkey(it));
        endfunction

        function void check_result(hcsk_pkg::result_t got);
            hcsk_pkg::result_t want;
            if (subkeys_due.size() == 0)
            begin
                $error("subkey result %h with no transaction outstanding", got);
                mismatches++;
                return;
            end
            want = subkeys_due.pop_front();
            // result_t is packed with subkey_part_0 in the top 64 bits
            for (int i = 0; i < 4; i++)
            begin
                if (got[255 - 64*i -: 64] !== want[255 - 64*i -: 64])
                begin
                    $error("subkey_part_%0d: expected %h, actual %h", i,
                           want[255 - 64*i -: 64], got[255 - 64*i -: 64]);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return subkeys_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    hcsk_pkg::item_t   item;
    logic              done;
    hcsk_pkg::result_t result;

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    hchacha20_subkey_derive_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    subkey_scoreboard sb = new();

    // ------------------------------------------------------------------
    // Monitor: samples pre-edge values at each rising edge. A transaction
    // is accepted when start is high and busy low; a result is taken
    // whenever done is high (it cannot be held off).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_item(item);
            if (done)
                sb.check_result(result);
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hchacha20_subkey_derive_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one transaction after an optional idle gap. Called at a rising
    // edge; returns at the edge that accepted the transaction, so a
    // back-to-back call keeps start high without dropping it.
    task automatic issue_derivation(input hcsk_pkg::item_t it, input int unsigned idle_cycles);
        if (idle_cycles != 0)
        begin
            start <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 150);
    endfunction

    // full-range random field, with occasional extremes and sparse patterns
    function automatic logic [63:0] pick_field();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return {$urandom, $urandom};
        else if (r < 85)
            return '0;
        else if (r < 90)
            return '1;
        else if (r < 95)
            return 64'd1 << $urandom_range(0, 63);
        else
            return ~(64'd1 << $urandom_range(0, 63));
    endfunction

    function automatic hcsk_pkg::item_t pick_item();
        hcsk_pkg::item_t it;
        it.key_part_0   = pick_field();
        it.key_part_1   = pick_field();
        it.key_part_2   = pick_field();
        it.key_part_3   = pick_field();
        it.nonce_part_0 = pick_field();
        it.nonce_part_1 = pick_field();
        return it;
    endfunction

    // all fields zero except one (0..5: key parts, then nonce parts)
    function automatic hcsk_pkg::item_t single_field(input int idx, input logic [63:0] v);
        hcsk_pkg::item_t it;
        it = '0;
        case (idx)
            0: it.key_part_0   = v;
            1: it.key_part_1   = v;
            2: it.key_part_2   = v;
            3: it.key_part_3   = v;
            4: it.nonce_part_0 = v;
            default: it.nonce_part_1 = v;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        hcsk_pkg::item_t   kat_item;
        hcsk_pkg::result_t kat_subkey;
        hcsk_pkg::result_t kat_model;
        hcsk_pkg::item_t   it;
        int unsigned       idle;
        bit                no_idle_stretch;
        int unsigned       drain;

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;

        // Published HChaCha20 test vector: key 00..1f, nonce
        // 000000090000004a0000000031415927. Confirms the model itself.
        kat_item.key_part_0   = 64'h07060504_03020100;
        kat_item.key_part_1   = 64'h0f0e0d0c_0b0a0908;
        kat_item.key_part_2   = 64'h17161514_13121110;
        kat_item.key_part_3   = 64'h1f1e1d1c_1b1a1918;
        kat_item.nonce_part_0 = 64'h4a000000_09000000;
        kat_item.nonce_part_1 = 64'h27594131_00000000;
        kat_subkey.subkey_part_0 = 64'hfe7bb227_423b4182;
        kat_subkey.subkey_part_1 = 64'h737d878a_50420ed3;
        kat_subkey.subkey_part_2 = 64'h53a8748a_d5e4f9a0;
        kat_subkey.subkey_part_3 = 64'hdcecd326_13c42ec1;
        kat_model = sb.hchacha_subkey(kat_item);
        if (kat_model !== kat_subkey)
        begin
            $error("known-answer subkey: expected %h, actual %h", kat_subkey, kat_model);
            sb.mismatches++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: extremes, single-field patterns, known vector ----
        issue_derivation('0, 0);
        issue_derivation('1, 0);
        issue_derivation(kat_item, 1);
        for (int f = 0; f < 6; f++)
        begin
            issue_derivation(single_field(f, '1), 0);
            issue_derivation(single_field(f, 64'd1), f % 2);
        end
        issue_derivation({6{64'h5555_5555_5555_5555}}, 0);
        issue_derivation({6{64'haaaa_aaaa_aaaa_aaaa}}, 0);
        issue_derivation({6{64'h8000_0000_0000_0000}}, 2);
        issue_derivation({6{64'h0000_0000_ffff_ffff}}, 0);
        issue_derivation({6{64'hffff_ffff_0000_0000}}, 0);

        // ---- random: stretches with and without idle gaps ----
        no_idle_stretch = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                no_idle_stretch = ($urandom_range(0, 2) == 0);
            // once, hold off until the pipeline has fully drained;
            // step one edge first so the last accepted transaction is noted
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                do
                    @(posedge clk);
                while (sb.outstanding() != 0);
            end
            it   = pick_item();
            idle = no_idle_stretch ? 0 : pick_idle();
            issue_derivation(it, idle);
        end
        start <= 1'b0;
        item  <= pick_item();

        // wait for every outstanding subkey, then a little longer for strays
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("hchacha20_subkey_derive_unit test passed");
        else
            $display("hchacha20_subkey_derive_unit test failed");
        $finish;
    end

endmodule

/* filelist.f */
src/hcsk_pkg.sv
src/hcsk_cell.sv
src/hchacha20_subkey_derive_unit.sv
dv/tb_top.sv
